>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Depends on nothing; active unless SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: label");
`define ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m: label");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NR(label, clk, prop)
`endif
`endif

>>> rtl/aes_rsu_pkg.sv
// Package for the AES round state unit: opcodes, S-box tables, GF(2^8) helpers.
// Depends on nothing.
package aes_rsu_pkg;

  typedef enum logic [2:0] {
    OP_LOAD      = 3'd0,
    OP_ADD_KEY   = 3'd1,
    OP_SUB       = 3'd2,
    OP_INV_SUB   = 3'd3,
    OP_SHIFT     = 3'd4,
    OP_INV_SHIFT = 3'd5,
    OP_MIX       = 3'd6,
    OP_INV_MIX   = 3'd7
  } op_e;

  localparam int unsigned NumBytes = 16;
  localparam int unsigned NumCols  = 4;

  // Byte 0 sits in the most significant bits of the packed vectors
  typedef logic [7:0]           byte_t;
  typedef byte_t [0:NumBytes-1] state_t;  // index = row + 4*column
  typedef byte_t [0:3]          col_t;

  typedef struct packed {
    op_e    op;
    state_t opnd;
  } req_t;

  // Lane control, shared by all columns
  typedef struct packed {
    logic   sub;
    logic   inv;
    logic   mix;
  } lane_ctl_t;

  function automatic byte_t xtime(byte_t a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  localparam byte_t SBOX_FWD [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam byte_t SBOX_INV [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

endpackage

>>> rtl/aes_rsu_if.sv
// Valid/ready channel interface carrying one payload of type T.
// Depends on nothing.
interface aes_rsu_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/aes_rsu_col.sv
// One column lane: SubBytes / inverse and MixColumns / inverse on four bytes.
// Depends on aes_rsu_pkg.
module aes_rsu_col (
  input  aes_rsu_pkg::lane_ctl_t ctl_i,
  input  aes_rsu_pkg::col_t      col_i,
  output aes_rsu_pkg::col_t      col_o
);

  aes_rsu_pkg::col_t sub_res;
  aes_rsu_pkg::col_t mix_res;
  aes_rsu_pkg::col_t x2, x4, x8;
  aes_rsu_pkg::col_t m3, m9, mb, md, me;

  // Byte substitution through the tables
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sub_res[r] = ctl_i.inv ? aes_rsu_pkg::SBOX_INV[col_i[r]]
                             : aes_rsu_pkg::SBOX_FWD[col_i[r]];
    end
  end

  // Column mix: products by 2,3 or by 9,b,d,e
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      x2[r] = aes_rsu_pkg::xtime(col_i[r]);
      x4[r] = aes_rsu_pkg::xtime(x2[r]);
      x8[r] = aes_rsu_pkg::xtime(x4[r]);
      m3[r] = x2[r] ^ col_i[r];
      m9[r] = x8[r] ^ col_i[r];
      mb[r] = x8[r] ^ x2[r] ^ col_i[r];
      md[r] = x8[r] ^ x4[r] ^ col_i[r];
      me[r] = x8[r] ^ x4[r] ^ x2[r];
    end
    for (int r = 0; r < 4; r++) begin
      if (ctl_i.inv) begin
        mix_res[r] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
      end else begin
        mix_res[r] = x2[r] ^ m3[(r+1)%4] ^ col_i[(r+2)%4] ^ col_i[(r+3)%4];
      end
    end
  end

  assign col_o = ctl_i.mix ? mix_res : (ctl_i.sub ? sub_res : col_i);

endmodule

>>> rtl/aes_round_state_unit.sv
// AES round state unit. Each accepted transfer applies one operation (load,
// add key, SubBytes, ShiftRows, MixColumns or an inverse) to the 16-byte state
// and returns the new state. Throughput is one operation per cycle unless the
// output stalls: four column lanes compute in parallel and a merge stage applies
// load, row shifts and key add before the state register, which doubles as the
// output register. A stalled output holds the state and blocks new input.
// Depends on aes_rsu_pkg, aes_rsu_if, aes_rsu_col and assert_macros.svh.
`include "assert_macros.svh"
module aes_round_state_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  aes_rsu_if.sink       in_i,
  aes_rsu_if.source     out_o
);

  aes_rsu_pkg::state_t    state_q, state_d, lane_out;
  aes_rsu_pkg::lane_ctl_t ctl;
  logic                   out_valid_q;
  logic                   in_xfer;

  // Ready whenever the result slot is free or is being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;

  assign ctl.sub = (in_i.data.op == aes_rsu_pkg::OP_SUB) ||
                   (in_i.data.op == aes_rsu_pkg::OP_INV_SUB);
  assign ctl.mix = (in_i.data.op == aes_rsu_pkg::OP_MIX) ||
                   (in_i.data.op == aes_rsu_pkg::OP_INV_MIX);
  assign ctl.inv = (in_i.data.op == aes_rsu_pkg::OP_INV_SUB) ||
                   (in_i.data.op == aes_rsu_pkg::OP_INV_MIX);

  // Column lanes
  for (genvar c = 0; c < aes_rsu_pkg::NumCols; c++) begin : g_lane
    aes_rsu_col u_col (
      .ctl_i (ctl),
      .col_i (state_q[4*c +: 4]),
      .col_o (lane_out[4*c +: 4])
    );
  end

  // Merge: row shifts, load and key add across columns
  always_comb begin
    state_d = lane_out;
    unique case (in_i.data.op)
      aes_rsu_pkg::OP_LOAD:    state_d = in_i.data.opnd;
      aes_rsu_pkg::OP_ADD_KEY: state_d = state_q ^ in_i.data.opnd;
      aes_rsu_pkg::OP_SHIFT: begin
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++)
            state_d[r + 4*c] = state_q[r + 4*((c + r) % 4)];
      end
      aes_rsu_pkg::OP_INV_SHIFT: begin
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++)
            state_d[r + 4*c] = state_q[r + 4*((c - r + 4) % 4)];
      end
      default: state_d = lane_out;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_q <= state_d;
      end
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = state_q;

  `ASSERT_IMPL(a_stall_holds, clk_i, rst_ni,
    (out_valid_q && !out_o.ready) |=> ($stable(state_q) && out_valid_q))
  `ASSERT_IMPL(a_xfer_valid, clk_i, rst_ni, in_xfer |=> out_valid_q)
  `ASSERT_IMPL(a_no_xfer_stall, clk_i, rst_ni,
    (out_valid_q && !out_o.ready) |-> !in_i.ready)

endmodule

>>> tb/sv/tb_aes_round_state_unit.sv
// Testbench for aes_round_state_unit: drives opcode/operand transfers and
// checks every returned state against a local AES round-transform predictor.
// Depends on aes_rsu_pkg, aes_rsu_if and the RTL of the block.
module tb_aes_round_state_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumRandom  = 1400;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PauseAt    = 700;   // sender drains before this item
  localparam int unsigned HoldAt     = 400;   // receiver long hold-off start
  localparam int unsigned HoldLen    = 100;
  localparam int unsigned QuietTail  = 150;   // last items go without idling

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  aes_rsu_if #(.T(aes_rsu_pkg::req_t))   in_ch ();
  aes_rsu_if #(.T(aes_rsu_pkg::state_t)) out_ch ();

  aes_round_state_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #1 clk_i = ~clk_i;

  aes_rsu_pkg::req_t   pending_reqs[$];
  aes_rsu_pkg::state_t expected_states[$];
  aes_rsu_pkg::state_t model_state;
  int unsigned offered_cnt = 0;
  int unsigned taken_cnt   = 0;
  int unsigned mismatches  = 0;
  int unsigned cycle_cnt   = 0;
  bit          stim_done   = 1'b0;

  // GF(2^8) arithmetic modulo 0x11b
  function automatic aes_rsu_pkg::byte_t gf_dbl(aes_rsu_pkg::byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic aes_rsu_pkg::byte_t gf_mult(aes_rsu_pkg::byte_t a,
                                                 aes_rsu_pkg::byte_t b);
    aes_rsu_pkg::byte_t acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = gf_dbl(a);
    end
    return acc;
  endfunction

  // a^254, zero maps to zero
  function automatic aes_rsu_pkg::byte_t gf_recip(aes_rsu_pkg::byte_t a);
    aes_rsu_pkg::byte_t r;
    r = 8'h01;
    for (int i = 0; i < 7; i++) begin
      a = gf_mult(a, a);
      r = gf_mult(r, a);
    end
    return r;
  endfunction

  function automatic aes_rsu_pkg::byte_t rot8(aes_rsu_pkg::byte_t x, int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  function automatic aes_rsu_pkg::byte_t sub_byte(aes_rsu_pkg::byte_t x);
    aes_rsu_pkg::byte_t b;
    b = gf_recip(x);
    return b ^ rot8(b, 1) ^ rot8(b, 2) ^ rot8(b, 3) ^ rot8(b, 4) ^ 8'h63;
  endfunction

  function automatic aes_rsu_pkg::byte_t inv_sub_byte(aes_rsu_pkg::byte_t y);
    return gf_recip(rot8(y, 1) ^ rot8(y, 3) ^ rot8(y, 6) ^ 8'h05);
  endfunction

  // New state after applying one operation
  function automatic aes_rsu_pkg::state_t apply_round_op(aes_rsu_pkg::state_t s,
                                                         aes_rsu_pkg::req_t r);
    aes_rsu_pkg::state_t t;
    aes_rsu_pkg::byte_t  cf[4];
    aes_rsu_pkg::byte_t  acc;
    t = s;
    case (r.op)
      aes_rsu_pkg::OP_LOAD:    t = r.opnd;
      aes_rsu_pkg::OP_ADD_KEY: for (int k = 0; k < 16; k++) t[k] = s[k] ^ r.opnd[k];
      aes_rsu_pkg::OP_SUB:     for (int k = 0; k < 16; k++) t[k] = sub_byte(s[k]);
      aes_rsu_pkg::OP_INV_SUB: for (int k = 0; k < 16; k++) t[k] = inv_sub_byte(s[k]);
      aes_rsu_pkg::OP_SHIFT:
        for (int rw = 0; rw < 4; rw++)
          for (int c = 0; c < 4; c++) t[rw + 4*c] = s[rw + 4*((c + rw) & 3)];
      aes_rsu_pkg::OP_INV_SHIFT:
        for (int rw = 0; rw < 4; rw++)
          for (int c = 0; c < 4; c++) t[rw + 4*c] = s[rw + 4*((c - rw + 4) & 3)];
      default: begin
        if (r.op == aes_rsu_pkg::OP_MIX) cf = '{8'h02, 8'h03, 8'h01, 8'h01};
        else                             cf = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        for (int c = 0; c < 4; c++)
          for (int rw = 0; rw < 4; rw++) begin
            acc = 8'h00;
            for (int j = 0; j < 4; j++) acc ^= gf_mult(s[4*c + j], cf[(j - rw + 4) & 3]);
            t[4*c + rw] = acc;
          end
      end
    endcase
    return t;
  endfunction

  // Byte 0 most significant in the high half, byte 15 least in the low half
  function automatic logic [63:0] half_of(aes_rsu_pkg::state_t s, int base);
    logic [63:0] v;
    v = '0;
    for (int k = 0; k < 8; k++) v = {v[55:0], s[base + k]};
    return v;
  endfunction

  function automatic void queue_item(aes_rsu_pkg::op_e op, logic [63:0] hi,
                                     logic [63:0] lo);
    aes_rsu_pkg::req_t r;
    r.op = op;
    for (int k = 0; k < 8; k++) begin
      r.opnd[k]     = hi[63 - 8*k -: 8];
      r.opnd[k + 8] = lo[63 - 8*k -: 8];
    end
    pending_reqs.push_back(r);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Stimulus: directed cases then a random mix of round sequences and noise
  initial begin
    int sel;
    queue_item(aes_rsu_pkg::OP_LOAD, '0, '0);
    queue_item(aes_rsu_pkg::OP_SUB, rand64(), rand64());   // operand must be ignored
    queue_item(aes_rsu_pkg::OP_INV_SUB, '1, '1);
    queue_item(aes_rsu_pkg::OP_INV_SUB, '0, '0);           // inverse of zero path
    queue_item(aes_rsu_pkg::OP_LOAD, '1, '1);
    queue_item(aes_rsu_pkg::OP_SUB, '0, '0);
    queue_item(aes_rsu_pkg::OP_MIX, '1, '1);
    queue_item(aes_rsu_pkg::OP_INV_MIX, '0, '0);
    queue_item(aes_rsu_pkg::OP_LOAD, 64'h0011223344556677, 64'h8899aabbccddeeff);
    queue_item(aes_rsu_pkg::OP_ADD_KEY, 64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    queue_item(aes_rsu_pkg::OP_SUB, '0, '0);
    queue_item(aes_rsu_pkg::OP_SHIFT, '1, '1);             // row zero stays put
    queue_item(aes_rsu_pkg::OP_MIX, '0, '0);
    queue_item(aes_rsu_pkg::OP_INV_MIX, rand64(), rand64());
    queue_item(aes_rsu_pkg::OP_INV_SHIFT, '0, '0);
    queue_item(aes_rsu_pkg::OP_INV_SUB, '0, '0);
    queue_item(aes_rsu_pkg::OP_ADD_KEY, '1, '1);
    queue_item(aes_rsu_pkg::OP_ADD_KEY, '0, '0);
    queue_item(aes_rsu_pkg::OP_SHIFT, '0, '0);
    queue_item(aes_rsu_pkg::OP_SHIFT, '0, '0);
    queue_item(aes_rsu_pkg::OP_INV_SHIFT, '1, '0);
    queue_item(aes_rsu_pkg::OP_LOAD, 64'h8000000000000001, 64'h0123456789abcdef);
    for (int i = 0; i < NumRandom; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 2) queue_item(aes_rsu_pkg::OP_LOAD, rand64(), rand64());
      else if (sel < 4) queue_item(aes_rsu_pkg::op_e'($urandom_range(1, 7)),
                                   rand64(), rand64());
      else begin
        // one full cipher or decipher round
        if ($urandom_range(0, 1)) begin
          queue_item(aes_rsu_pkg::OP_SUB, rand64(), rand64());
          queue_item(aes_rsu_pkg::OP_SHIFT, rand64(), rand64());
          queue_item(aes_rsu_pkg::OP_MIX, rand64(), rand64());
        end else begin
          queue_item(aes_rsu_pkg::OP_INV_MIX, rand64(), rand64());
          queue_item(aes_rsu_pkg::OP_INV_SHIFT, rand64(), rand64());
          queue_item(aes_rsu_pkg::OP_INV_SUB, rand64(), rand64());
        end
        queue_item(aes_rsu_pkg::OP_ADD_KEY, rand64(), rand64());
        i += 3;
      end
    end
    stim_done = 1'b1;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_reqs.size() == 0 && taken_cnt == offered_cnt
          && expected_states.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_states.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Sender: presents queued items at the falling edge
  int unsigned send_idle = 0;
  bit          drained   = 1'b0;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
  end
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && taken_cnt != offered_cnt) begin
        // transfer still pending, hold the item
      end else if (send_idle > 0) begin
        in_ch.valid <= 1'b0;
        send_idle--;
      end else if (offered_cnt == PauseAt && !drained) begin
        in_ch.valid <= 1'b0;
        if (expected_states.size() == 0 && taken_cnt == offered_cnt) drained = 1'b1;
      end else if (pending_reqs.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > QuietTail && $urandom_range(0, 7) == 0) begin
        in_ch.valid <= 1'b0;
        send_idle = $urandom_range(0, 4);
      end else begin
        in_ch.data  <= pending_reqs.pop_front();
        in_ch.valid <= 1'b1;
        offered_cnt++;
      end
    end
  end

  // Receiver: random ready bursts plus one long hold-off
  int unsigned recv_idle = 0;
  int unsigned hold_left = 0;
  bit          held      = 1'b0;
  initial out_ch.ready = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (!held && taken_cnt >= HoldAt) begin
        out_ch.ready <= 1'b0;
        hold_left = HoldLen - 1;
        held = 1'b1;
      end else if (recv_idle > 0) begin
        out_ch.ready <= 1'b0;
        recv_idle--;
      end else if (pending_reqs.size() > QuietTail && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        recv_idle = $urandom_range(0, 4);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on input transfers, check output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    aes_rsu_pkg::state_t got, want;
    if (!rst_ni) begin
      model_state = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        model_state = apply_round_op(model_state, in_ch.data);
        expected_states.push_back(model_state);
        taken_cnt++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_states.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %h_%h",
                                        half_of(got, 0), half_of(got, 8));
          mismatches++;
        end else begin
          want = expected_states.pop_front();
          if (half_of(got, 0) !== half_of(want, 0) || half_of(got, 8) !== half_of(want, 8)) begin
            if (mismatches < 10)
              $display("mismatch: state_hi exp %h got %h, state_lo exp %h got %h",
                       half_of(want, 0), half_of(got, 0), half_of(want, 8), half_of(got, 8));
            mismatches++;
          end
        end
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
